// ===== design/sd_spi_host_sequencer_macros.svh =====
// Assertion macros for the SD SPI host sequencer.
`ifndef SD_SPI_HOST_SEQUENCER_MACROS_SVH
`define SD_SPI_HOST_SEQUENCER_MACROS_SVH
`ifndef SYNTH
`define SSH_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SSH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SSH_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SSH_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/sdspi_pkg.sv =====
// Shared types and constants of the SD SPI host sequencer.
package sdspi_pkg;
   localparam int BLOCK_BYTES = 512;
   localparam int POLL_LIMIT  = 255;
   localparam int WAKE_BYTES  = 10;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] MODE_BYTE  = 2'd0;
   localparam logic [1:0] MODE_TICK  = 2'd1;
   localparam logic [1:0] MODE_START = 2'd2;
   localparam logic [1:0] OP_INIT  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;
   localparam logic [1:0] CSR_INIT  = 2'd0;
   localparam logic [1:0] CSR_WRITE = 2'd1;
   localparam logic [1:0] CSR_READ  = 2'd2;
   localparam logic [1:0] CSR_READY = 2'd3;

   localparam logic [3:0] ST_OK = 4'd0, ST_BUSY = 4'd1, ST_RESET = 4'd2, ST_ECHO = 4'd3,
      ST_ACMD41 = 4'd4, ST_CMD58 = 4'd5, ST_WRCMD = 4'd6, ST_WRBUSY = 4'd7,
      ST_WRDATA = 4'd8, ST_RDCMD = 4'd9, ST_RDTIMEOUT = 4'd10, ST_TOKEN = 4'd11;

   localparam logic [5:0] CMD_GO_IDLE = 6'd0, CMD_SEND_IF = 6'd8, CMD_READ = 6'd17,
      CMD_WRITE = 6'd24, CMD_ACMD41 = 6'd41, CMD_APP = 6'd55, CMD_OCR = 6'd58;

   localparam logic [1:0] KIND_V1 = 2'd0, KIND_V2 = 2'd1, KIND_HC = 2'd2;

   typedef enum logic [3:0] {
      PH_IDLE, PH_WAKE, PH_RDY, PH_CMD, PH_R1, PH_R7, PH_OCR, PH_WW1, PH_WW2,
      PH_WTOK, PH_WDATA, PH_WCRC, PH_WRESP, PH_RSTART, PH_RDATA
   } phase_type;

   typedef enum logic [1:0] {
      EV_BYTE, EV_TICK, EV_START, EV_NONE
   } event_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [1:0]  operation;
      logic [31:0] block_address;
      logic [7:0]  rx_byte;
      logic [7:0]  write_byte;
   } req_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       chip_select_high;
      logic       read_valid;
      logic [7:0] read_byte;
      logic       read_last;
      logic       done_res;
      logic [3:0] status_code;
      logic [1:0] card_kind;
      logic       busy_res;
   } rsp_type;

   // Classified item handed from front to back.
   typedef struct packed {
      event_type   kind;
      logic [1:0]  operation;
      logic [31:0] block_address;
      logic [7:0]  rx_byte;
      logic [7:0]  write_byte;
   } cmd_type;
endpackage

// ===== design/sd_spi_host_sequencer.sv =====
// Top level of the SD card SPI-mode host sequencer.
// The sequencer takes one transfer per clock while the queue has room: each input
// transfer is an exchanged SPI byte, a millisecond tick or a start request, and
// each yields exactly one result transfer carrying the next byte to shift, chip
// select, any read data byte and completion status. A front stage classifies
// transfers into a two-entry queue; the back engine consumes one queued transfer
// per cycle into a one-entry result register while that register is empty or
// popped, so sustained throughput is one transfer per cycle, via a queue entry and
// the result register. Configuration writes change timeouts and are taken at once.
module sd_spi_host_sequencer import sdspi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  req_type     req_data,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   logic    cmd_valid, cmd_take;
   cmd_type cmd_data;

   // Front: accept and classify transfers.
   sdspi_front u_front (
      .clock(clock), .reset(reset), .req_push(req_push), .req_full(req_full),
      .req_data(req_data), .cmd_valid(cmd_valid), .cmd_data(cmd_data),
      .cmd_take(cmd_take)
   );

   // Back: run the card sequence and hold the result.
   sdspi_engine u_engine (
      .clock(clock), .reset(reset), .csr_write(csr_write), .csr_index(csr_index),
      .csr_data(csr_data), .cmd_valid(cmd_valid), .cmd_data(cmd_data),
      .cmd_take(cmd_take), .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_data(rsp_data)
   );
endmodule

// ===== design/sdspi_front.sv =====
// Front end: accepts items, classifies them and queues them for the engine.
module sdspi_front import sdspi_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    cmd_valid,
   output cmd_type cmd_data,
   input  logic    cmd_take
);
   localparam int PW = $clog2(QUEUE_DEPTH);
   cmd_type          q_ff [QUEUE_DEPTH];
   cmd_type          q_in;
   logic [PW-1:0]    wp_ff, wp_in, rp_ff, rp_in;
   logic [PW:0]      cnt_ff, cnt_in;
   logic             push_ok, pop_ok;

   always_comb begin
      case (req_data.mode)
         MODE_BYTE:  q_in.kind = EV_BYTE;
         MODE_TICK:  q_in.kind = EV_TICK;
         MODE_START: q_in.kind = EV_START;
         default:    q_in.kind = EV_NONE;
      endcase
      q_in.operation     = req_data.operation;
      q_in.block_address = req_data.block_address;
      q_in.rx_byte       = req_data.rx_byte;
      q_in.write_byte    = req_data.write_byte;
   end

   assign req_full  = (cnt_ff == (PW+1)'(QUEUE_DEPTH));
   assign push_ok   = req_push && !req_full;
   assign cmd_valid = (cnt_ff != '0);
   assign pop_ok    = cmd_valid && cmd_take;
   assign cmd_data  = q_ff[rp_ff];
   assign wp_in  = push_ok ? wp_ff + 1'b1 : wp_ff;
   assign rp_in  = pop_ok ? rp_ff + 1'b1 : rp_ff;
   assign cnt_in = cnt_ff + (PW+1)'(push_ok) - (PW+1)'(pop_ok);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push_ok) begin
         q_ff[wp_ff] <= q_in;
      end
   end
endmodule

// ===== design/sdspi_engine.sv =====
// Back end: the card sequencer state machine and its result register.
module sdspi_engine import sdspi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   input  logic        cmd_valid,
   input  cmd_type     cmd_data,
   output logic        cmd_take,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data
);
`include "sd_spi_host_sequencer_macros.svh"
   logic [15:0] init_to_ff, write_to_ff, read_to_ff, ready_to_ff;
   phase_type   phase_ff, phase_in;
   logic [1:0]  kind_ff, kind_in;
   logic        sel_ff, sel_in;
   logic [9:0]  bc_ff, bc_in;
   logic [7:0]  poll_ff, poll_in;
   logic [15:0] loop_ff, loop_in, wait_ff, wait_in;
   logic [31:0] arg_ff, arg_in;
   logic [7:0]  pend_ff, pend_in;
   logic [5:0]  cmd_ff, cmd_in;
   logic [3:0]  stat_ff, stat_in;
   logic        rv, rl, done;
   logic [7:0]  rb;
   logic        out_full_ff, out_full_in;
   rsp_type     out_ff, out_in;
   logic [7:0]  rx;
   logic        fin_req, sc_req;
   logic [3:0]  fin_code;
   logic [5:0]  sc_cmd;
   logic [31:0] sc_arg;

   assign cmd_take  = cmd_valid && (!out_full_ff || rsp_pop);
   assign rsp_empty = !out_full_ff;
   assign rsp_data  = out_ff;
   assign rx        = cmd_data.rx_byte;

   // Next state of the sequencer.
   always_comb begin
      phase_in = phase_ff; kind_in = kind_ff; sel_in = sel_ff; bc_in = bc_ff;
      poll_in = poll_ff; loop_in = loop_ff; wait_in = wait_ff; arg_in = arg_ff;
      pend_in = pend_ff; cmd_in = cmd_ff; stat_in = stat_ff;
      fin_req = 1'b0; fin_code = ST_OK; sc_req = 1'b0; sc_cmd = CMD_GO_IDLE; sc_arg = '0;
      if (cmd_data.kind == EV_TICK) begin
         if (loop_ff != 16'hFFFF) loop_in = loop_ff + 16'd1;
         if (wait_ff != 16'hFFFF) wait_in = wait_ff + 16'd1;
      end else if (cmd_data.kind == EV_START && phase_ff == PH_IDLE
                   && cmd_data.operation != 2'd3) begin
         if (cmd_data.operation == OP_INIT) begin
            sel_in = 1'b1; loop_in = '0; bc_in = '0; phase_in = PH_WAKE; pend_in = 8'hFF;
         end else begin
            sel_in = 1'b0; sc_req = 1'b1;
            sc_cmd = (cmd_data.operation == OP_READ) ? CMD_READ : CMD_WRITE;
            sc_arg = (kind_ff != KIND_HC) ? {cmd_data.block_address[22:0], 9'd0}
                                          : cmd_data.block_address;
         end
      end else if (cmd_data.kind == EV_BYTE && phase_ff != PH_IDLE) begin
         case (phase_ff)
            PH_WAKE: begin
               bc_in = bc_ff + 10'd1;
               if (bc_in < 10'(WAKE_BYTES)) pend_in = 8'hFF;
               else begin sel_in = 1'b0; sc_req = 1'b1; sc_cmd = CMD_GO_IDLE; end
            end
            PH_RDY: begin
               if (rx == 8'hFF) begin
                  phase_in = PH_CMD; bc_in = '0; pend_in = {2'b01, cmd_ff};
               end else if (wait_ff >= ready_to_ff) begin
                  fin_req = 1'b1; fin_code = ST_BUSY;
               end else pend_in = 8'hFF;
            end
            PH_CMD: begin
               if (bc_ff < 10'd4) begin
                  case (bc_ff[1:0])
                     2'd0:    pend_in = arg_ff[31:24];
                     2'd1:    pend_in = arg_ff[23:16];
                     2'd2:    pend_in = arg_ff[15:8];
                     default: pend_in = arg_ff[7:0];
                  endcase
                  bc_in = bc_ff + 10'd1;
               end else if (bc_ff == 10'd4) begin
                  pend_in = (cmd_ff == CMD_GO_IDLE) ? 8'h95 :
                            (cmd_ff == CMD_SEND_IF) ? 8'h87 : 8'hFF;
                  bc_in = bc_ff + 10'd1;
               end else begin
                  phase_in = PH_R1; poll_in = '0; pend_in = 8'hFF;
               end
            end
            PH_R1: begin
               if (!rx[7] || poll_ff >= 8'(POLL_LIMIT)) begin
                  case (cmd_ff)
                     CMD_GO_IDLE: begin
                        if (rx == 8'h01) begin
                           sc_req = 1'b1; sc_cmd = CMD_SEND_IF; sc_arg = 32'h1AA;
                        end else if (loop_ff > init_to_ff) begin
                           fin_req = 1'b1; fin_code = ST_RESET;
                        end else begin sc_req = 1'b1; sc_cmd = CMD_GO_IDLE; end
                     end
                     CMD_SEND_IF: begin
                        if (rx[2]) begin
                           kind_in = KIND_V1; sc_req = 1'b1; sc_cmd = CMD_APP;
                        end else begin
                           phase_in = PH_R7; bc_in = '0; pend_in = 8'hFF;
                        end
                     end
                     CMD_APP: begin
                        sc_req = 1'b1; sc_cmd = CMD_ACMD41;
                        sc_arg = (kind_ff == KIND_V2) ? 32'h4000_0000 : 32'h0;
                     end
                     CMD_ACMD41: begin
                        if (rx == 8'h00) begin
                           if (kind_ff == KIND_V2) begin sc_req = 1'b1; sc_cmd = CMD_OCR; end
                           else begin fin_req = 1'b1; fin_code = ST_OK; end
                        end else if (loop_ff > init_to_ff) begin
                           fin_req = 1'b1; fin_code = ST_ACMD41;
                        end else begin sc_req = 1'b1; sc_cmd = CMD_APP; end
                     end
                     CMD_OCR: begin
                        if (rx != 8'h00) begin fin_req = 1'b1; fin_code = ST_CMD58; end
                        else begin phase_in = PH_OCR; bc_in = '0; pend_in = 8'hFF; end
                     end
                     CMD_WRITE: begin
                        if (rx != 8'h00) begin fin_req = 1'b1; fin_code = ST_WRCMD; end
                        else begin phase_in = PH_WW1; wait_in = '0; pend_in = 8'hFF; end
                     end
                     default: begin
                        if (rx != 8'h00) begin fin_req = 1'b1; fin_code = ST_RDCMD; end
                        else begin phase_in = PH_RSTART; wait_in = '0; pend_in = 8'hFF; end
                     end
                  endcase
               end else begin
                  poll_in = poll_ff + 8'd1; pend_in = 8'hFF;
               end
            end
            PH_R7: begin
               bc_in = bc_ff + 10'd1;
               if (bc_in < 10'd4) pend_in = 8'hFF;
               else if (rx != 8'hAA) begin fin_req = 1'b1; fin_code = ST_ECHO; end
               else begin kind_in = KIND_V2; sc_req = 1'b1; sc_cmd = CMD_APP; end
            end
            PH_OCR: begin
               if (bc_ff == '0 && rx[7:6] == 2'b11) kind_in = KIND_HC;
               bc_in = bc_ff + 10'd1;
               if (bc_in < 10'd4) pend_in = 8'hFF;
               else begin fin_req = 1'b1; fin_code = ST_OK; end
            end
            PH_WW1: begin
               if (rx == 8'hFF) begin phase_in = PH_WW2; wait_in = '0; pend_in = 8'hFF; end
               else if (wait_ff >= write_to_ff) begin fin_req = 1'b1; fin_code = ST_WRBUSY; end
               else pend_in = 8'hFF;
            end
            PH_WW2: begin
               if (rx == 8'hFF || wait_ff >= write_to_ff) begin
                  phase_in = PH_WTOK; pend_in = 8'hFE;
               end else pend_in = 8'hFF;
            end
            PH_WTOK: begin
               phase_in = PH_WDATA; bc_in = 10'd1; pend_in = cmd_data.write_byte;
            end
            PH_WDATA: begin
               if ({1'b0, bc_ff} < 11'(BLOCK_BYTES)) begin
                  pend_in = cmd_data.write_byte; bc_in = bc_ff + 10'd1;
               end else begin phase_in = PH_WCRC; bc_in = '0; pend_in = 8'hFF; end
            end
            PH_WCRC: begin
               bc_in = bc_ff + 10'd1;
               pend_in = 8'hFF;
               if (bc_in >= 10'd2) phase_in = PH_WRESP;
            end
            PH_WRESP: begin
               fin_req = 1'b1;
               fin_code = (rx[4:0] != 5'h05) ? ST_WRDATA : ST_OK;
            end
            PH_RSTART: begin
               if (rx == 8'hFF) begin
                  if (wait_ff > read_to_ff) begin fin_req = 1'b1; fin_code = ST_RDTIMEOUT; end
                  else pend_in = 8'hFF;
               end else if (rx == 8'hFE) begin
                  phase_in = PH_RDATA; bc_in = '0; pend_in = 8'hFF;
               end else begin fin_req = 1'b1; fin_code = ST_TOKEN; end
            end
            PH_RDATA: begin
               bc_in = bc_ff + 10'd1;
               if ({1'b0, bc_in} >= 11'(BLOCK_BYTES) || bc_in == '0) begin
                  fin_req = 1'b1; fin_code = ST_OK;
               end else pend_in = 8'hFF;
            end
            default: phase_in = PH_IDLE;
         endcase
      end
      if (sc_req) begin
         cmd_in = sc_cmd; arg_in = sc_arg; phase_in = PH_RDY; wait_in = '0; pend_in = 8'hFF;
      end
      if (fin_req) begin
         phase_in = PH_IDLE; sel_in = 1'b1; pend_in = '0; stat_in = fin_code;
      end
   end

   // Result fields for this item.
   always_comb begin
      rv = (cmd_data.kind == EV_BYTE) && (phase_ff == PH_RDATA);
      rb = rv ? rx : 8'h00;
      rl = rv && fin_req;
      done = fin_req;
      out_in.tx_valid         = (phase_in != PH_IDLE);
      out_in.tx_byte          = (phase_in != PH_IDLE) ? pend_in : 8'h00;
      out_in.chip_select_high = sel_in;
      out_in.read_valid       = rv;
      out_in.read_byte        = rb;
      out_in.read_last        = rl;
      out_in.done_res         = done;
      out_in.status_code      = stat_in;
      out_in.card_kind        = kind_in;
      out_in.busy_res         = (phase_in != PH_IDLE);
      out_full_in = cmd_take ? 1'b1 : (rsp_pop ? 1'b0 : out_full_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_to_ff <= 16'd2000; write_to_ff <= 16'd600;
         read_to_ff <= 16'd300;  ready_to_ff <= 16'd300;
         phase_ff <= PH_IDLE; kind_ff <= KIND_V1; sel_ff <= 1'b1; bc_ff <= '0;
         poll_ff <= '0; loop_ff <= '0; wait_ff <= '0; arg_ff <= '0;
         pend_ff <= '0; cmd_ff <= CMD_GO_IDLE; stat_ff <= ST_OK; out_full_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_INIT:  init_to_ff  <= csr_data;
               CSR_WRITE: write_to_ff <= csr_data;
               CSR_READ:  read_to_ff  <= csr_data;
               default:   ready_to_ff <= csr_data;
            endcase
         end
         out_full_ff <= out_full_in;
         if (cmd_take) begin
            phase_ff <= phase_in; kind_ff <= kind_in; sel_ff <= sel_in; bc_ff <= bc_in;
            poll_ff <= poll_in; loop_ff <= loop_in; wait_ff <= wait_in; arg_ff <= arg_in;
            pend_ff <= pend_in; cmd_ff <= cmd_in; stat_ff <= stat_in;
         end
      end
      if (cmd_take) out_ff <= out_in;
   end

   `SSH_ASSERT_IMPL(a_take_room, clock, reset, cmd_take, !out_full_ff || rsp_pop)
   `SSH_ASSERT_NEXT(a_take_fills, clock, reset, cmd_take, !rsp_empty)
   `SSH_ASSERT_IMPL(a_last_done, clock, reset, !rsp_empty && rsp_data.read_last,
                    rsp_data.done_res && rsp_data.read_valid)
   `SSH_ASSERT_IMPL(a_idle_cs, clock, reset, phase_ff == PH_IDLE, sel_ff)
endmodule
